>>> rtl/core/enc_odo_pkg.sv
// Package for the wheel encoder odometry block: item structs, operation and
// register codes, controller/datapath command structs and sequencing constants.
// No dependencies.
package enc_odo_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int PROD_W      = 96;
    localparam int MUL_CYCLES  = 32;
    localparam int DIV_CYCLES  = 96;
    localparam int CNT_W       = 7;

    localparam logic [31:0] SPEED_SCALE = 32'd1000000;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_ZERO   = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_CPR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CIRC = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR  = 2'd2;

    localparam logic [1:0] STEP_DELTA = 2'd0;
    localparam logic [1:0] STEP_TOTAL = 2'd1;
    localparam logic [1:0] STEP_SPEED = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] counter_value;
        logic [23:0] dt_us;
    } in_item_t;

    typedef struct packed {
        logic signed [16:0] delta_ticks;
        logic signed [63:0] total_ticks;
        logic signed [39:0] delta_distance_um;
        logic signed [63:0] total_distance_um;
        logic signed [59:0] speed_um_per_s;
        logic               calibrated;
        logic               running;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       mul_init;
        logic       mul_step;
        logic       div_step;
        logic       store;
        logic [1:0] step;
    } cmd_t;

    typedef struct packed {
        logic need_math;
        logic dt_nonzero;
    } status_t;

endpackage

>>> rtl/core/encoder_odometry.sv
// Top level of the wheel encoder odometry block: controller plus datapath.
// Depends on enc_odo_pkg, enc_odo_ctrl and enc_odo_dp.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid / in_stall    in_item (operation, counter, dt)
//   out       source     out_valid / out_stall  out_item (counts, distances, speed)
//   cfg       sink       cfg_write              cfg_index, cfg_data
//
// Start, zero and updates before start or while uncalibrated go from acceptance
// through setup straight to the output state, with no arithmetic. A calibrated
// update runs up to three passes (setup, multiply, divide, store) for delta
// distance, total distance and speed in one shared unit; the speed pass is not
// run with zero elapsed time. in_stall stays high until the
// result is taken; the result holds under out_stall. Reset is asynchronous.
module encoder_odometry #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  enc_odo_pkg::in_item_t               in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output enc_odo_pkg::out_item_t              out_item,
    input  logic                                cfg_write,
    input  logic [enc_odo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [enc_odo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import enc_odo_pkg::*;

    // Commands from the controller and flags back from the datapath.
    cmd_t    cmd;
    status_t status;

    enc_odo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    enc_odo_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule

>>> rtl/core/enc_odo_ctrl.sv
// Controller for the odometry block: sequences item load, the shift-add
// multiply, the restoring divide and the result stores. Uses enc_odo_pkg.
module enc_odo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output enc_odo_pkg::cmd_t    cmd,
    input  enc_odo_pkg::status_t status
);
    import enc_odo_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_STORE = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_DELTA;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!status.need_math || (step_reg == STEP_SPEED && !status.dt_nonzero))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(MUL_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (step_reg == STEP_SPEED)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= STEP_DELTA;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 2'd3)
        else $error("step index out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SETUP))
        else $error("accepted item did not start processing");

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result waits");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(DIV_CYCLES))
        else $error("cycle counter overran");

endmodule

>>> rtl/core/enc_odo_dp.sv
// Datapath for the odometry block: configuration and count state, shared
// shift-add multiplier and restoring divider, result register. Uses enc_odo_pkg.
module enc_odo_dp #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [enc_odo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [enc_odo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  enc_odo_pkg::in_item_t                in_item,
    input  enc_odo_pkg::cmd_t                    cmd,
    output enc_odo_pkg::status_t                 status,
    output enc_odo_pkg::out_item_t               out_item
);
    import enc_odo_pkg::*;

    localparam logic [63:0] LIM40 = 64'h0000_007F_FFFF_FFFF;
    localparam logic [63:0] LIM64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // Magnitude of a quotient with sign applied, clamped to [-lim-1, lim].
    function automatic logic [63:0] sign_sat(input logic neg, input logic [PROD_W-1:0] q,
                                             input logic [63:0] lim);
        logic [63:0] m;
        m = (q[PROD_W-1:64] != '0) ? '1 : q[63:0];
        if (neg)
        begin
            if (m > lim + 64'd1)
            begin
                m = lim + 64'd1;
            end
            sign_sat = 64'd0 - m;
        end
        else
        begin
            sign_sat = (m > lim) ? lim : m;
        end
    endfunction

    logic [23:0]             cpr_reg, circ_reg;
    logic                    dirneg_reg;
    logic [COUNTER_BITS-1:0] last_reg;
    logic [63:0]             total_reg;
    logic                    started_reg;

    logic [23:0]             dt_reg;
    logic [COUNTER_BITS-1:0] mag_reg;
    logic                    neg_reg;
    logic                    need_reg;

    logic [PROD_W-1:0]       acc_reg, a_reg;
    logic [31:0]             b_reg;
    logic [23:0]             d_reg, rem_reg;
    out_item_t               res_reg;

    logic [COUNTER_BITS-1:0] cur, raw, mag;
    logic                    neg, cal;
    logic [63:0]             dbits, new_total;
    logic                    tneg;
    logic [63:0]             tmag;
    logic [63:0]             dd_ext, dmag;
    logic                    dneg;
    logic [24:0]             div_r;
    logic                    div_ge;
    out_item_t               load_res;

    always_comb
    begin
        cur   = COUNTER_BITS'(in_item.counter_value);
        raw   = cur - last_reg;
        mag   = raw[COUNTER_BITS-1] ? (~raw + 1'b1) : raw;
        neg   = (raw[COUNTER_BITS-1] ^ dirneg_reg) && (mag != '0);
        dbits = neg ? (64'd0 - 64'(mag)) : 64'(mag);
        new_total = total_reg + dbits;
        cal   = (cpr_reg != '0) && (circ_reg != '0);
        tneg  = total_reg[63];
        tmag  = tneg ? (64'd0 - total_reg) : total_reg;
        dd_ext = 64'(signed'(res_reg.delta_distance_um));
        dneg  = dd_ext[63];
        dmag  = dneg ? (64'd0 - dd_ext) : dd_ext;
        div_r  = {rem_reg, acc_reg[PROD_W-1]};
        div_ge = (div_r >= {1'b0, d_reg});
    end

    // Result fields known at load time; the distances and speed follow later.
    always_comb
    begin
        load_res = '0;
        case (in_item.operation)
            OP_START:
            begin
                load_res.calibrated = cal;
                load_res.running    = 1'b1;
            end
            OP_UPDATE:
            begin
                if (started_reg)
                begin
                    load_res.delta_ticks = dbits[16:0];
                    load_res.total_ticks = new_total;
                    load_res.calibrated  = cal;
                    load_res.running     = 1'b1;
                end
            end
            default:
            begin
                load_res.calibrated = cal;
                load_res.running    = started_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg     <= '0;
            circ_reg    <= '0;
            dirneg_reg  <= 1'b0;
            last_reg    <= '0;
            total_reg   <= '0;
            started_reg <= 1'b0;
            need_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CPR:  cpr_reg    <= cfg_data;
                    CFG_CIRC: circ_reg   <= cfg_data;
                    CFG_DIR:  dirneg_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
            if (cmd.load)
            begin
                need_reg <= (in_item.operation == OP_UPDATE) && started_reg && cal;
                case (in_item.operation)
                    OP_START:
                    begin
                        last_reg    <= cur;
                        total_reg   <= '0;
                        started_reg <= 1'b1;
                    end
                    OP_ZERO:
                    begin
                        last_reg  <= '0;
                        total_reg <= '0;
                    end
                    OP_UPDATE:
                    begin
                        if (started_reg)
                        begin
                            last_reg  <= cur;
                            total_reg <= new_total;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload: operands, multiply/divide registers and the result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dt_reg  <= in_item.dt_us;
            mag_reg <= mag;
            neg_reg <= neg;
            res_reg <= load_res;
        end
        if (cmd.mul_init)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            case (cmd.step)
                STEP_DELTA:
                begin
                    a_reg <= PROD_W'(mag_reg);
                    b_reg <= {circ_reg, 8'd0};
                    d_reg <= cpr_reg;
                end
                STEP_TOTAL:
                begin
                    a_reg <= PROD_W'(tmag);
                    b_reg <= {circ_reg, 8'd0};
                    d_reg <= cpr_reg;
                end
                default:
                begin
                    a_reg <= PROD_W'(dmag);
                    b_reg <= SPEED_SCALE;
                    d_reg <= dt_reg;
                end
            endcase
        end
        if (cmd.mul_step)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[PROD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[31:1]};
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? 24'(div_r - {1'b0, d_reg}) : div_r[23:0];
            acc_reg <= {acc_reg[PROD_W-2:0], div_ge};
        end
        if (cmd.store)
        begin
            case (cmd.step)
                STEP_DELTA:
                begin
                    res_reg.delta_distance_um <= 40'(sign_sat(neg_reg, acc_reg, LIM40));
                end
                STEP_TOTAL:
                begin
                    res_reg.total_distance_um <= sign_sat(tneg, acc_reg, LIM64);
                end
                default:
                begin
                    res_reg.speed_um_per_s <= dneg ? (60'd0 - acc_reg[59:0])
                                                   : acc_reg[59:0];
                end
            endcase
        end
    end

    assign status.need_math  = need_reg;
    assign status.dt_nonzero = (dt_reg != '0);
    assign out_item          = res_reg;

endmodule
